// ----- rtl/ssrr_pkg.sv -----
// shared types, constants and the leader function for the rrip replacement block
package ssrr_pkg;
	localparam int NUM_SETS_D    = 2048;
	localparam int NUM_WAYS_D    = 16;
	localparam int SIG_BITS_D    = 6;
	localparam int DUEL_BITS_D   = 10;
	localparam int NUM_LEADERS_D = 32;
	localparam int ADDR_BITS_D   = 48;

	localparam logic [1:0] RRPV_TOP    = 2'd3;
	localparam logic [1:0] NEAR_INSERT = 2'd0;
	localparam logic [1:0] FAR_INSERT  = 2'd2;

	localparam logic [1:0] ROLE_FOLLOW = 2'd0;
	localparam logic [1:0] ROLE_SHIP   = 2'd1;
	localparam logic [1:0] ROLE_BRRIP  = 2'd2;

	localparam logic CFG_REUSE_THR  = 1'b0;
	localparam logic CFG_STRIDE_THR = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CNT,
		ST_WRITE
	} state_t;

	// leader role of a set, from the leader index formulas (set count is a power of two)
	function automatic logic [1:0] leader_of(input int set, input int nsets, input int nlead);
		logic [1:0] r;
		r = ROLE_FOLLOW;
		for (int i = 0; i < nlead; i++) begin
			if (r == ROLE_FOLLOW && ((i * 37) & (nsets - 1)) == set) r = ROLE_SHIP;
			if (r == ROLE_FOLLOW && ((i * 71 + 13) & (nsets - 1)) == set) r = ROLE_BRRIP;
		end
		return r;
	endfunction
endpackage

// ----- rtl/ssrr_ram.sv -----
// generic single port ram with registered read
module ssrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ----- rtl/ssrr_age.sv -----
// rrip aging and victim search over one set row
module ssrr_age #(
	parameter int NUM_WAYS = 16
) (
	input  logic [2*NUM_WAYS-1:0]       rrpv_row,
	output logic [2*NUM_WAYS-1:0]       aged_row,
	output logic [$clog2(NUM_WAYS)-1:0] victim
);
	localparam int WB = $clog2(NUM_WAYS);
	logic [1:0] top;
	logic [1:0] add;
	logic       found;

	// max rrpv, add so the max reaches the top, first way at top
	always_comb begin
		top = 2'd0;
		for (int w = 0; w < NUM_WAYS; w++)
			if (rrpv_row[2*w +: 2] > top) top = rrpv_row[2*w +: 2];
		add = ssrr_pkg::RRPV_TOP - top;
		victim = '0;
		found = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			aged_row[2*w +: 2] = rrpv_row[2*w +: 2] + add;
			if (!found && aged_row[2*w +: 2] == ssrr_pkg::RRPV_TOP) begin
				victim = WB'(w);
				found = 1'b1;
			end
		end
	end
endmodule

// ----- rtl/ship_stream_rrip_replacement.sv -----
// top level of the rrip replacement block with ship and stride detection
//
//  channel   handshake            payload
//  access    start / busy         set_index is_hit hit_way pc paddr
//  result    done strobe          way inserted_rrpv streaming reuse_predicted
//  config    cfg_valid/cfg_ready  cfg_index cfg_data
//
// an access runs from accept to the next accept through read of set row and
// stream, the counter state, write back, then the idle cycle that shows the result.
// after reset a clearing pass walks all three memories one set a cycle, over all
// NUM_SETS sets, with busy high; config writes are taken at any time.
// results appear for one cycle with done; the receiver cannot stall.
module ship_stream_rrip_replacement #(
	parameter int NUM_SETS    = ssrr_pkg::NUM_SETS_D,
	parameter int NUM_WAYS    = ssrr_pkg::NUM_WAYS_D,
	parameter int SIG_BITS    = ssrr_pkg::SIG_BITS_D,
	parameter int DUEL_BITS   = ssrr_pkg::DUEL_BITS_D,
	parameter int NUM_LEADERS = ssrr_pkg::NUM_LEADERS_D,
	parameter int ADDR_BITS   = ssrr_pkg::ADDR_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [10:0] set_index,
	input  logic        is_hit,
	input  logic [3:0]  hit_way,
	input  logic [47:0] pc,
	input  logic [47:0] paddr,
	output logic        done,
	output logic [3:0]  way,
	output logic [1:0]  inserted_rrpv,
	output logic        streaming,
	output logic        reuse_predicted,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data
);
	localparam int SB  = $clog2(NUM_SETS);
	localparam int WB  = $clog2(NUM_WAYS);
	localparam int NS  = 1 << SIG_BITS;
	localparam int SW  = ADDR_BITS + 1;
	localparam int LW  = NUM_WAYS * (2 + SIG_BITS + 1);
	localparam int STW = ADDR_BITS + SW + 2 + 1 + 1;
	localparam logic [DUEL_BITS-1:0] DUEL_MAX = {DUEL_BITS{1'b1}};
	localparam logic [DUEL_BITS-1:0] DUEL_MID = DUEL_MAX >> 1;

	ssrr_pkg::state_t state_q, state_nx;
	logic [SB-1:0] clr_q;
	logic [1:0] reuse_thr_q, stride_thr_q;
	logic [DUEL_BITS-1:0] duel_q;

	// latched access
	logic [SB-1:0] set_q;
	logic hit_q;
	logic [WB-1:0] hw_q;
	logic [SIG_BITS-1:0] sig_q;
	logic [ADDR_BITS-1:0] addr_q;

	// memories
	logic line_we, st_we, cnt_we;
	logic [SB-1:0] mem_addr;
	logic [LW-1:0] line_rd, line_wd, line_upd;
	logic [STW-1:0] st_rd, st_wd, st_upd;
	logic [2*NS-1:0] cnt_rd, cnt_wd, cnt_upd;

	// decoded line row
	logic [2*NUM_WAYS-1:0] rrpv_row, aged_row, rrpv_new;
	logic [SIG_BITS*NUM_WAYS-1:0] sig_row, sig_new;
	logic [NUM_WAYS-1:0] val_row, val_new;
	logic [WB-1:0] victim;

	// captured after read
	logic [WB-1:0] way_q;
	logic [2*NUM_WAYS-1:0] rrpv_q;
	logic [SIG_BITS*NUM_WAYS-1:0] lsig_q;
	logic [NUM_WAYS-1:0] lval_q;
	logic flag_q;

	ssrr_ram #(.WIDTH(LW), .DEPTH(NUM_SETS)) u_line (
		.clk(clk), .we(line_we), .addr(mem_addr), .wdata(line_wd), .rdata(line_rd));
	ssrr_ram #(.WIDTH(STW), .DEPTH(NUM_SETS)) u_stream (
		.clk(clk), .we(st_we), .addr(mem_addr), .wdata(st_wd), .rdata(st_rd));
	ssrr_ram #(.WIDTH(2*NS), .DEPTH(NUM_SETS)) u_cnt (
		.clk(clk), .we(cnt_we), .addr(mem_addr), .wdata(cnt_wd), .rdata(cnt_rd));

	ssrr_age #(.NUM_WAYS(NUM_WAYS)) u_age (
		.rrpv_row(rrpv_row), .aged_row(aged_row), .victim(victim));

	// line row layout: valid, signatures, rrpv
	always_comb begin
		rrpv_row = line_rd[2*NUM_WAYS-1:0];
		sig_row  = line_rd[2*NUM_WAYS +: SIG_BITS*NUM_WAYS];
		val_row  = line_rd[LW-1 -: NUM_WAYS];
	end

	// stream update
	logic [ADDR_BITS-1:0] prev_addr;
	logic [SW-1:0] last_stride, stride;
	logic [1:0] run_cnt, run_new;
	logic flag_new, st_ok;
	always_comb begin
		st_ok       = st_rd[STW-1];
		prev_addr   = st_ok ? st_rd[ADDR_BITS-1:0] : '0;
		last_stride = st_ok ? st_rd[ADDR_BITS +: SW] : '0;
		run_cnt     = st_ok ? st_rd[ADDR_BITS+SW +: 2] : '0;
		stride = (prev_addr == '0) ? '0
			: SW'({1'b0, addr_q} - {1'b0, prev_addr});
		if (stride != '0 && stride == last_stride) begin
			run_new  = (run_cnt < 2'd3) ? run_cnt + 2'd1 : run_cnt;
			flag_new = (st_ok && st_rd[ADDR_BITS+SW+2]) || (run_new >= stride_thr_q);
		end else begin
			run_new  = 2'd1;
			flag_new = 1'b0;
		end
		st_upd = {1'b1, flag_new, run_new, stride, addr_q};
	end

	// counter update in the write state
	logic [SIG_BITS-1:0] vsig;
	logic [1:0] c_cur, c_new, role;
	logic pred;
	logic [1:0] ins;
	always_comb begin
		cnt_upd = cnt_rd;
		vsig = lsig_q[SIG_BITS*way_q +: SIG_BITS];
		role = ssrr_pkg::leader_of(int'(set_q), NUM_SETS, NUM_LEADERS);
		c_cur = cnt_rd[2*sig_q +: 2];
		if (hit_q) begin
			c_new = (c_cur < 2'd3) ? c_cur + 2'd1 : c_cur;
			cnt_upd[2*sig_q +: 2] = c_new;
		end else begin
			if (lval_q[way_q] && cnt_upd[2*vsig +: 2] != 2'd0)
				cnt_upd[2*vsig +: 2] = cnt_upd[2*vsig +: 2] - 2'd1;
			c_new = cnt_upd[2*sig_q +: 2];
		end
		pred = c_new >= reuse_thr_q;
		if (hit_q) ins = ssrr_pkg::NEAR_INSERT;
		else if (role == ssrr_pkg::ROLE_BRRIP) ins = ssrr_pkg::FAR_INSERT;
		else if (flag_q) ins = ssrr_pkg::RRPV_TOP;
		else if (role == ssrr_pkg::ROLE_SHIP || duel_q < DUEL_MID)
			ins = pred ? ssrr_pkg::NEAR_INSERT : ssrr_pkg::FAR_INSERT;
		else ins = ssrr_pkg::FAR_INSERT;
		rrpv_new = rrpv_q;
		rrpv_new[2*way_q +: 2] = ins;
		sig_new = lsig_q;
		sig_new[SIG_BITS*way_q +: SIG_BITS] = sig_q;
		val_new = lval_q;
		val_new[way_q] = 1'b1;
		line_upd = {val_new, sig_new, rrpv_new};
	end

	// clearing rows: line valid bits low and rrpv 3, stream zero, counters of 1
	logic [LW-1:0] clr_line;
	logic [2*NS-1:0] ones_row;
	always_comb begin
		ones_row = '0;
		for (int i = 0; i < NS; i++) ones_row[2*i +: 2] = 2'd1;
		clr_line = '0;
		clr_line[2*NUM_WAYS-1:0] = {NUM_WAYS{ssrr_pkg::RRPV_TOP}};
	end

	// memory controls; idle addresses the incoming set so data is ready in read
	logic clearing;
	assign clearing = (state_q == ssrr_pkg::ST_CLEAR);
	assign mem_addr = clearing ? clr_q
		: ((state_q == ssrr_pkg::ST_IDLE) ? set_index[SB-1:0] : set_q);
	assign cnt_we   = clearing || (state_q == ssrr_pkg::ST_WRITE);
	assign st_we    = clearing || (state_q == ssrr_pkg::ST_READ);
	assign line_we  = clearing || (state_q == ssrr_pkg::ST_WRITE);
	assign cnt_wd   = clearing ? ones_row : cnt_upd;
	assign st_wd    = clearing ? '0 : st_upd;
	assign line_wd  = clearing ? clr_line : line_upd;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ssrr_pkg::ST_CLEAR: if (clr_q == SB'(NUM_SETS - 1)) state_nx = ssrr_pkg::ST_IDLE;
			ssrr_pkg::ST_IDLE:  if (start) state_nx = ssrr_pkg::ST_READ;
			ssrr_pkg::ST_READ:  state_nx = ssrr_pkg::ST_CNT;
			ssrr_pkg::ST_CNT:   state_nx = ssrr_pkg::ST_WRITE;
			ssrr_pkg::ST_WRITE: state_nx = ssrr_pkg::ST_IDLE;
			default:            state_nx = ssrr_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != ssrr_pkg::ST_IDLE);
		cfg_ready = 1'b1;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ssrr_pkg::ST_CLEAR;
			clr_q        <= '0;
			reuse_thr_q  <= 2'd1;
			stride_thr_q <= 2'd3;
			duel_q       <= DUEL_MID;
			done         <= 1'b0;
		end else begin
			state_q <= state_nx;
			done    <= (state_q == ssrr_pkg::ST_WRITE);
			if (clearing) clr_q <= clr_q + SB'(1);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ssrr_pkg::CFG_REUSE_THR) reuse_thr_q <= cfg_data;
				else stride_thr_q <= cfg_data;
			end
			if (state_q == ssrr_pkg::ST_WRITE && !hit_q) begin
				if (role == ssrr_pkg::ROLE_SHIP && duel_q != DUEL_MAX)
					duel_q <= duel_q + DUEL_BITS'(1);
				else if (role == ssrr_pkg::ROLE_BRRIP && duel_q != '0)
					duel_q <= duel_q - DUEL_BITS'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ssrr_pkg::ST_IDLE && start) begin
			set_q  <= set_index[SB-1:0];
			hit_q  <= is_hit;
			hw_q   <= hit_way[WB-1:0];
			sig_q  <= SIG_BITS'(pc[47:2] ^ 46'(set_index[SB-1:0]));
			addr_q <= paddr[ADDR_BITS-1:0];
		end
		if (state_q == ssrr_pkg::ST_READ) begin
			flag_q <= flag_new;
			if (hit_q) begin
				way_q  <= hw_q;
				rrpv_q <= rrpv_row;
			end else begin
				way_q  <= victim;
				rrpv_q <= aged_row;
			end
			lsig_q <= sig_row;
			lval_q <= val_row;
		end
		if (state_q == ssrr_pkg::ST_WRITE) begin
			way             <= 4'(way_q);
			inserted_rrpv   <= ins;
			streaming       <= flag_q;
			reuse_predicted <= pred;
		end
	end
endmodule
